// File: rtl/core/ptlm_pkg.sv
// package: shared types, constants and the divider step for the pedal level map
`default_nettype none

package ptlm_pkg;

    // field and work widths
    localparam int POS_W     = 10;
    localparam int PCT_W     = 7;
    localparam int LVL_W     = 11;
    localparam int WORK_W    = 13;
    localparam int NUM_W     = 19;
    localparam int DEN_W     = 10;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIFF_W    = PCT_W + 1;
    localparam int PROD_W    = 17;
    localparam int MAG_W     = 14;
    localparam int TDIV_W    = 11;
    localparam int MUL_W     = 30;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = POS_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // mapping constants
    localparam int LVL_NEAR_FULL = 979;
    localparam int LVL_FULL      = 1000;
    localparam int LVL_HALF      = 500;
    localparam int PCT_FULL      = 100;
    localparam int PCT_SCALE     = 10;
    localparam int POS_FULL      = 1000;
    localparam int UP_SAT_Q      = LVL_NEAR_FULL - LVL_HALF;

    // x / 10 as (x * RECIP_10) >> RECIP_SHIFT, exact for x below 43000
    localparam int RECIP_10    = 52429;
    localparam int RECIP_SHIFT = 19;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGEN_MAX_POS  = 3'd0,
        CFG_REGEN_MIN_POS  = 3'd1,
        CFG_FWD_START_POS  = 3'd2,
        CFG_HALF_POWER_POS = 3'd3,
        CFG_CREEP_PCT      = 3'd4,
        CFG_MIN_REGEN_PCT  = 3'd5,
        CFG_MAX_REGEN_PCT  = 3'd6
    } t_cfg_idx;

    // which rule produces the level
    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_CREEP,
        KIND_REGEN,
        KIND_FWD_LO,
        KIND_FWD_UP
    } t_kind;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] addr;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_wr;

    // classified item passed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [PCT_W-1:0]  pct;
        logic [DIFF_W-1:0] diff;
    } t_job;

    // one divider stage
    typedef struct packed {
        t_kind             kind;
        logic [DEN_W-1:0]  rem;
        logic [NUM_W-1:0]  nq;
        logic [DEN_W-1:0]  den;
        logic [PCT_W-1:0]  pct;
        logic [DIFF_W-1:0] diff;
    } t_div;

    typedef struct packed {
        t_kind             kind;
        logic [WORK_W-1:0] lvl;
        logic [PROD_W-1:0] prod;
        logic [PCT_W-1:0]  pct;
    } t_post1;

    typedef struct packed {
        t_kind             kind;
        logic [WORK_W-1:0] lvl;
        logic              neg;
        logic [TDIV_W-1:0] tdiv;
        logic [PCT_W-1:0]  pct;
    } t_post2;

    // one restoring division bit: numerator bits shift out, quotient bits shift in
    function automatic t_div div_step(input t_div s);
        t_div             d;
        logic [DEN_W:0]   r;
        logic             ge;
        d    = s;
        r    = {s.rem, s.nq[NUM_W-1]};
        ge   = (r >= {1'b0, s.den});
        d.nq = {s.nq[NUM_W-2:0], ge};
        if (ge) begin
            d.rem = DEN_W'(r - {1'b0, s.den});
        end else begin
            d.rem = r[DEN_W-1:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pedal_to_torque_level_map_core.sv
// top level: pedal position to signed drive level map on stream channels
// throughput: one sample per cycle while the output is not stalled, through the 19-stage radix-2 divider pipeline
// a short queue lets the front keep taking samples while the output is stalled
// reset (synchronous, active low) empties queue and pipeline and loads the
// register defaults, half power position at 500 and all others at zero
`default_nettype none

module pedal_to_torque_level_map_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port, index as in the register list
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [9:0]  i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [ptlm_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [9:0] pedal_position, [15:10] zero
    input  wire logic        s_axis_tuser,   // [0] signal_valid
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [ptlm_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // [10:0] drive_level, [15:11] zero
);
    import ptlm_pkg::*;

    t_cfg_wr cfg;
    t_job    front_job;
    t_job    queue_job;
    logic    q_full, q_empty, q_pop, push;
    logic    out_vld;
    logic [LVL_W-1:0] out_level;

    // config write bundle
    always_comb begin
        cfg.we   = i_cfg_wr_en;
        cfg.addr = i_cfg_addr;
        cfg.data = i_cfg_wdata;
    end

    // a transfer is taken whenever the queue has room
    always_comb begin
        s_axis_tready = !q_full;
        push          = s_axis_tvalid && !q_full;
    end

    // front classifies the sample into creep, regen, forward or zero
    ptlm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pedal     (s_axis_tdata[POS_W-1:0]),
        .i_sig_valid (s_axis_tuser),
        .o_job       (front_job)
    );

    // decoupling queue between front and back
    ptlm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (queue_job),
        .o_empty (q_empty)
    );

    // back divides, scales regen, clamps and holds the result for the output transfer
    ptlm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (queue_job),
        .i_job_vld (!q_empty),
        .o_pop     (q_pop),
        .o_vld     (out_vld),
        .i_ready   (m_axis_tready),
        .o_level   (out_level)
    );

    always_comb begin
        m_axis_tvalid = out_vld;
        m_axis_tdata  = {(OUT_TDATA_W - LVL_W)'(0), out_level};
    end

endmodule

`default_nettype wire

// File: rtl/core/ptlm_front.sv
// front: configuration registers and rule classification of each pedal sample
`default_nettype none

module ptlm_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ptlm_pkg::t_cfg_wr        i_cfg,
    input  wire logic [ptlm_pkg::POS_W-1:0] i_pedal,
    input  wire logic                     i_sig_valid,
    output ptlm_pkg::t_job                o_job
);
    import ptlm_pkg::*;

    logic [POS_W-1:0] r_rg_max_pos;
    logic [POS_W-1:0] r_rg_min_pos;
    logic [POS_W-1:0] r_fwd_start;
    logic [POS_W-1:0] r_half_pos;
    logic [PCT_W-1:0] r_creep_pct;
    logic [PCT_W-1:0] r_min_rg_pct;
    logic [PCT_W-1:0] r_max_rg_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rg_max_pos <= '0;
            r_rg_min_pos <= '0;
            r_fwd_start  <= '0;
            r_half_pos   <= POS_W'(LVL_HALF);
            r_creep_pct  <= '0;
            r_min_rg_pct <= '0;
            r_max_rg_pct <= '0;
        end else if (i_cfg.we) begin
            case (t_cfg_idx'(i_cfg.addr))
                CFG_REGEN_MAX_POS:  r_rg_max_pos <= i_cfg.data;
                CFG_REGEN_MIN_POS:  r_rg_min_pos <= i_cfg.data;
                CFG_FWD_START_POS:  r_fwd_start  <= i_cfg.data;
                CFG_HALF_POWER_POS: r_half_pos   <= i_cfg.data;
                CFG_CREEP_PCT:      r_creep_pct  <= i_cfg.data[PCT_W-1:0];
                CFG_MIN_REGEN_PCT:  r_min_rg_pct <= i_cfg.data[PCT_W-1:0];
                CFG_MAX_REGEN_PCT:  r_max_rg_pct <= i_cfg.data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic fwd, le_half, lo_nz, up_ok, in_regen, rg_nz, creep_hit;

    always_comb begin
        fwd       = (i_pedal >= r_fwd_start);
        le_half   = (i_pedal <= r_half_pos);
        lo_nz     = (r_half_pos != r_fwd_start);
        up_ok     = (r_half_pos < POS_W'(POS_FULL));
        in_regen  = (i_pedal <= r_rg_min_pos) && (i_pedal >= r_rg_max_pos);
        rg_nz     = (r_rg_min_pos != r_rg_max_pos);
        creep_hit = (i_pedal == '0) && (r_creep_pct != '0);

        o_job.kind = KIND_ZERO;
        o_job.num  = '0;
        o_job.den  = DEN_W'(1);
        o_job.pct  = r_min_rg_pct;
        o_job.diff = {1'b0, r_max_rg_pct} - {1'b0, r_min_rg_pct};

        if (!i_sig_valid) begin
            o_job.kind = KIND_ZERO;
        end else if (fwd && !le_half) begin
            if (up_ok) begin
                o_job.kind = KIND_FWD_UP;
                o_job.num  = NUM_W'(i_pedal - r_half_pos) * NUM_W'(LVL_HALF);
                o_job.den  = DEN_W'(POS_FULL) - r_half_pos;
            end
        end else if (fwd && lo_nz) begin
            o_job.kind = KIND_FWD_LO;
            o_job.num  = NUM_W'(i_pedal - r_fwd_start) * NUM_W'(LVL_HALF);
            o_job.den  = r_half_pos - r_fwd_start;
        end else if (creep_hit) begin
            o_job.kind = KIND_CREEP;
            o_job.pct  = r_creep_pct;
        end else if (in_regen && rg_nz) begin
            o_job.kind = KIND_REGEN;
            o_job.num  = NUM_W'(i_pedal - r_rg_max_pos) * NUM_W'(PCT_FULL);
            o_job.den  = r_rg_min_pos - r_rg_max_pos;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ptlm_queue.sv
// queue: short register fifo between front and back
`default_nettype none

module ptlm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ptlm_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output ptlm_pkg::t_job      o_data,
    output logic                o_empty
);
    import ptlm_pkg::*;

    t_job              r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    always_comb begin
        o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_empty = (r_count == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_data  = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ptlm_back.sv
// back: pipelined divider, regen scaling and level clamp with output register
`default_nettype none

module ptlm_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ptlm_pkg::t_job           i_job,
    input  wire logic                     i_job_vld,
    output logic                          o_pop,
    output logic                          o_vld,
    input  wire logic                     i_ready,
    output logic [ptlm_pkg::LVL_W-1:0]    o_level
);
    import ptlm_pkg::*;

    t_div               r_div [0:DIV_STEPS];
    logic [DIV_STEPS:0] r_vld;
    t_post1             r_p1;
    t_post2             r_p2;
    logic               r_p1_vld, r_p2_vld, r_out_vld;
    logic [LVL_W-1:0]   r_out;

    t_div               n_load;
    t_post1             n_p1;
    t_post2             n_p2;
    logic [LVL_W-1:0]   n_out;
    logic               en;

    // pipeline moves as a whole whenever the output slot is free or being taken
    always_comb begin
        en    = !r_out_vld || i_ready;
        o_pop = en && i_job_vld;
    end

    always_comb begin
        n_load.kind = i_job.kind;
        n_load.rem  = '0;
        n_load.nq   = i_job.num;
        n_load.den  = i_job.den;
        n_load.pct  = i_job.pct;
        n_load.diff = i_job.diff;
    end

    // quotient out of the divider
    logic [NUM_W-1:0]  q;
    logic [DIFF_W:0]   rg_t;

    always_comb begin
        q         = r_div[DIV_STEPS].nq;
        rg_t      = {1'b0, DIFF_W'(PCT_FULL) - q[DIFF_W-1:0]};
        n_p1.kind = r_div[DIV_STEPS].kind;
        n_p1.pct  = r_div[DIV_STEPS].pct;
        n_p1.prod = PROD_W'($signed(r_div[DIV_STEPS].diff)) * PROD_W'($signed(rg_t));
        case (r_div[DIV_STEPS].kind)
            KIND_CREEP: begin
                n_p1.lvl = WORK_W'(r_div[DIV_STEPS].pct) * WORK_W'(PCT_SCALE);
            end
            KIND_FWD_LO: begin
                if (q > NUM_W'(LVL_NEAR_FULL)) begin
                    n_p1.lvl = WORK_W'(LVL_FULL);
                end else begin
                    n_p1.lvl = WORK_W'(q[POS_W-1:0]);
                end
            end
            KIND_FWD_UP: begin
                if (q > NUM_W'(UP_SAT_Q)) begin
                    n_p1.lvl = WORK_W'(LVL_FULL);
                end else begin
                    n_p1.lvl = WORK_W'(LVL_HALF) + WORK_W'(q[POS_W-2:0]);
                end
            end
            default: begin
                n_p1.lvl = '0;
            end
        endcase
    end

    // truncating divide of the regen product by ten, done on the magnitude
    logic [PROD_W-1:0] prod_abs;
    logic [MUL_W-1:0]  mul;

    always_comb begin
        n_p2.kind = r_p1.kind;
        n_p2.lvl  = r_p1.lvl;
        n_p2.pct  = r_p1.pct;
        n_p2.neg  = r_p1.prod[PROD_W-1];
        if (n_p2.neg) begin
            prod_abs = PROD_W'(-r_p1.prod);
        end else begin
            prod_abs = r_p1.prod;
        end
        mul       = MUL_W'(prod_abs[MAG_W-1:0]) * MUL_W'(RECIP_10);
        n_p2.tdiv = mul[RECIP_SHIFT+TDIV_W-1:RECIP_SHIFT];
    end

    logic signed [WORK_W-1:0] rg_base, rg_tsig, lvl;
    localparam logic signed [WORK_W-1:0] S_NEAR = WORK_W'(LVL_NEAR_FULL);
    localparam logic signed [WORK_W-1:0] S_FULL = WORK_W'(LVL_FULL);
    localparam logic signed [WORK_W-1:0] S_NEG_FULL = -WORK_W'(LVL_FULL);

    always_comb begin
        rg_base = -(WORK_W'(r_p2.pct) * WORK_W'(PCT_SCALE));
        if (r_p2.neg) begin
            rg_tsig = -WORK_W'(r_p2.tdiv);
        end else begin
            rg_tsig = WORK_W'(r_p2.tdiv);
        end
        if (r_p2.kind == KIND_REGEN) begin
            lvl = rg_base - rg_tsig;
        end else begin
            lvl = r_p2.lvl;
        end
        if (lvl > S_NEAR) begin
            n_out = LVL_W'(S_FULL);
        end else if (lvl < S_NEG_FULL) begin
            n_out = LVL_W'(S_NEG_FULL);
        end else begin
            n_out = LVL_W'(lvl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[DIV_STEPS-1:0], i_job_vld};
            r_p1_vld  <= r_vld[DIV_STEPS];
            r_p2_vld  <= r_p1_vld;
            r_out_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0] <= n_load;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_div[k] <= div_step(r_div[k-1]);
            end
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_out <= n_out;
        end
    end

    always_comb begin
        o_vld   = r_out_vld;
        o_level = r_out;
    end

endmodule

`default_nettype wire

// File: verif/pedal_to_torque_level_map_core_test.sv
// testbench for the pedal to drive level map core: directed and random samples, scoreboard checked
`timescale 1ns / 1ps

module pedal_to_torque_level_map_core_test;

    import ptlm_pkg::*;

    // register index the block does not decode, writes to it must be ignored
    localparam logic [2:0] CFG_SPARE_IDX = 3'd7;

    localparam int RUN_LIMIT   = 200000;   // cycles before the run is declared hung
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off, fills queue and pipeline
    localparam int TAIL_CYCLES = 40;       // beyond the pipeline latency
    localparam int PHASE_ITEMS = 80;

    // keeps its own copy of the registers and the levels still owed by the block
    class drive_level_tracker;
        logic [9:0] regen_max_pos;
        logic [9:0] regen_min_pos;
        logic [9:0] fwd_start_pos;
        logic [9:0] half_power_pos;
        logic [6:0] creep_pct;
        logic [6:0] min_regen_pct;
        logic [6:0] max_regen_pct;
        logic signed [10:0] levels_due[$];
        int errors;

        function new();
            regen_max_pos  = '0;
            regen_min_pos  = '0;
            fwd_start_pos  = '0;
            half_power_pos = 10'd500;
            creep_pct      = '0;
            min_regen_pct  = '0;
            max_regen_pct  = '0;
            errors         = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [9:0] val);
            case (idx)
                CFG_REGEN_MAX_POS:  regen_max_pos  = val;
                CFG_REGEN_MIN_POS:  regen_min_pos  = val;
                CFG_FWD_START_POS:  fwd_start_pos  = val;
                CFG_HALF_POWER_POS: half_power_pos = val;
                CFG_CREEP_PCT:      creep_pct      = val[6:0];
                CFG_MIN_REGEN_PCT:  min_regen_pct  = val[6:0];
                CFG_MAX_REGEN_PCT:  max_regen_pct  = val[6:0];
                default: ;
            endcase
        endfunction

        // wide signed arithmetic, division truncating toward zero
        function logic signed [10:0] predict_drive_level(logic [9:0] pos, logic ok);
            int p;
            int lvl;
            int span;
            int off;
            int rmax;
            int rmin;
            int fstart;
            int half;
            int creep;
            int lo_pct;
            int hi_pct;
            p      = pos;
            rmax   = regen_max_pos;
            rmin   = regen_min_pos;
            fstart = fwd_start_pos;
            half   = half_power_pos;
            creep  = creep_pct;
            lo_pct = min_regen_pct;
            hi_pct = max_regen_pct;
            lvl    = 0;
            if (!ok) begin
                return '0;
            end
            if (p == 0 && creep > 0) begin
                lvl = 10 * creep;
            end else if (p <= rmin && p >= rmax) begin
                span = rmin - rmax;
                off  = p - rmax;
                if (span != 0) begin
                    lvl = -10 * lo_pct + (hi_pct - lo_pct) * (100 - off * 100 / span) / -10;
                end
            end
            // forward rule is evaluated last and overrides
            if (p >= fstart) begin
                if (p <= half) begin
                    span = half - fstart;
                    if (span != 0) begin
                        lvl = 500 * (p - fstart) / span;
                    end
                end else begin
                    span = 1000 - half;
                    if (span > 0) begin
                        lvl = 500 + 500 * (p - half) / span;
                    end else begin
                        lvl = 0;
                    end
                end
            end
            if (lvl > 979) begin
                lvl = 1000;
            end
            if (lvl < -1000) begin
                lvl = -1000;
            end
            return lvl[10:0];
        endfunction

        function void note_sample(logic [9:0] pos, logic ok);
            levels_due.push_back(predict_drive_level(pos, ok));
        endfunction

        function void check_level(logic [10:0] got);
            logic signed [10:0] want;
            if (levels_due.size() == 0) begin
                $error("drive_level: no level expected, got %0d", $signed(got));
                errors++;
            end else begin
                want = levels_due.pop_front();
                if (got !== want) begin
                    $error("drive_level: expected %0d, got %0d", want, $signed(got));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return levels_due.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [2:0]  i_cfg_addr    = '0;
    logic [9:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [9:0] pedal_position, [15:10] zero
    logic        s_axis_tuser  = 1'b0;  // [0] signal_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [10:0] drive_level, [15:11] zero

    drive_level_tracker tracker = new();

    int          gap_max   = 16;   // sender idle cycles per sample, upper bound
    int          stall_max = 16;   // receiver stall cycles per level, upper bound
    bit          hold_req  = 1'b0;
    int unsigned cycle_count = 0;

    pedal_to_torque_level_map_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("** pedal_to_torque_level_map_core: FAILED **");
            $finish;
        end
    end

    // both channels are observed with the values present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_sample(s_axis_tdata[9:0], s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_level(m_axis_tdata[10:0]);
            end
        end
    end

    // receiver: random stall before each transfer, occasionally a long hold-off
    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = $urandom_range(stall_max, 0);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // one register write; the enable stays up so back-to-back writes need no re-raise
    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tracker.set_register(idx, val);
    endtask

    task automatic program_regs(input logic [9:0] rmax, input logic [9:0] rmin,
                                input logic [9:0] fstart, input logic [9:0] half,
                                input logic [9:0] creep, input logic [9:0] lo_pct,
                                input logic [9:0] hi_pct);
        write_reg(CFG_REGEN_MAX_POS, rmax);
        write_reg(CFG_REGEN_MIN_POS, rmin);
        write_reg(CFG_FWD_START_POS, fstart);
        write_reg(CFG_HALF_POWER_POS, half);
        write_reg(CFG_CREEP_PCT, creep);
        write_reg(CFG_MIN_REGEN_PCT, lo_pct);
        write_reg(CFG_MAX_REGEN_PCT, hi_pct);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // returns at the edge of the transfer with tvalid still high
    task automatic send_sample(input logic [9:0] pos, input logic ok);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, pos};
        s_axis_tuser  <= ok;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // sender goes quiet until every level owed has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // pedal values biased toward the configured break points
    function automatic logic [9:0] pick_pedal();
        int sel;
        int base;
        sel = $urandom_range(9, 0);
        case (sel)
            0: return '0;
            1: return 10'($urandom_range(1023, 1001));
            2, 3: begin
                case ($urandom_range(5, 0))
                    0: base = tracker.regen_max_pos;
                    1: base = tracker.regen_min_pos;
                    2: base = tracker.fwd_start_pos;
                    3: base = tracker.half_power_pos;
                    4: base = 980;
                    default: base = 1000;
                endcase
                base = base + $urandom_range(2, 0) - 1;
                if (base < 0) begin
                    base = 0;
                end
                return base[9:0];
            end
            default: return 10'($urandom_range(1000, 0));
        endcase
    endfunction

    task automatic random_samples(input int count);
        repeat (count) begin
            send_sample(pick_pedal(), ($urandom_range(9, 0) != 0));
        end
    endtask

    initial begin
        int a;
        int b;
        int c;
        int d;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: forward range covers everything, half power at 500
        send_sample(10'd0, 1'b1);
        send_sample(10'd1, 1'b1);
        send_sample(10'd250, 1'b1);
        send_sample(10'd500, 1'b1);
        send_sample(10'd501, 1'b1);
        send_sample(10'd990, 1'b1);
        send_sample(10'd1000, 1'b1);
        send_sample(10'd1023, 1'b1);
        send_sample(10'd1023, 1'b0);   // invalid signal forces zero
        send_sample(10'd0, 1'b0);
        wait_drained();

        // typical map: creep, regen ramp, dead band, two forward ramps
        program_regs(10'd50, 10'd250, 10'd300, 10'd700, 10'd5, 10'd10, 10'd40);
        send_sample(10'd0, 1'b1);      // creep
        send_sample(10'd0, 1'b0);
        send_sample(10'd10, 1'b1);     // below regen maximum
        send_sample(10'd50, 1'b1);
        send_sample(10'd150, 1'b1);
        send_sample(10'd250, 1'b1);
        send_sample(10'd275, 1'b1);    // between regen and forward
        send_sample(10'd300, 1'b1);
        send_sample(10'd700, 1'b1);
        send_sample(10'd701, 1'b1);
        send_sample(10'd980, 1'b1);    // upper forward ramp
        send_sample(10'd1000, 1'b1);
        send_sample(10'd1023, 1'b1);   // beyond full scale
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            gap_max   = 16;
            stall_max = 16;
            case (ph)
                0: program_regs('0, '0, '0, '0, '0, '0, '0);   // zero lower forward range
                1: program_regs(10'd1023, 10'd1023, 10'd1023, 10'd1023,
                                10'd127, 10'd127, 10'd127);        // everything past range
                2: begin
                    // zero regen range, random forward start, half power at 1000 so no upper range
                    a = $urandom_range(1000, 0);
                    c = $urandom_range(1000, 0);
                    program_regs(a[9:0], a[9:0], c[9:0], 10'd1000,
                                 10'd100, 10'd100, 10'd100);
                end
                3: begin
                    // wide regen ramp, no idling on either side
                    gap_max   = 0;
                    stall_max = 0;
                    program_regs(10'd1, 10'd1000, 10'd1000, 10'd1000,
                                 10'd100, 10'd0, 10'd100);
                end
                5: begin
                    program_regs(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
                                 10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
                                 10'($urandom_range(127, 0)), 10'($urandom_range(127, 0)),
                                 10'($urandom_range(127, 0)));
                    write_reg(CFG_SPARE_IDX, 10'($urandom_range(1023, 0)));
                    i_cfg_wr_en <= 1'b0;
                    @(posedge i_clk);
                end
                default: begin
                    // ordered break points with random spacing
                    a = $urandom_range(400, 0);
                    b = a + $urandom_range(300, 0);
                    c = b + $urandom_range(200, 0);
                    d = c + $urandom_range(1000 - c, 0);
                    program_regs(a[9:0], b[9:0], c[9:0], d[9:0],
                                 10'($urandom_range(100, 0)), 10'($urandom_range(100, 0)),
                                 10'($urandom_range(100, 0)));
                end
            endcase
            if (ph == 4) begin
                // receiver holds off while the sender keeps pushing
                gap_max  = 0;
                hold_req = 1'b1;
            end
            random_samples(PHASE_ITEMS);
            wait_drained();
        end

        stall_max = 16;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("** pedal_to_torque_level_map_core: PASSED **");
        end else begin
            $display("** pedal_to_torque_level_map_core: FAILED **");
        end
        $finish;
    end

endmodule
